// File: hdl/display_command_framer_core_defines.svh
// Assertion macros used by the framer RTL.
// Each macro expects clk and rst_n in scope.
`ifndef DISPLAY_COMMAND_FRAMER_CORE_DEFINES_SVH
`define DISPLAY_COMMAND_FRAMER_CORE_DEFINES_SVH

// Same-cycle implication.
`define DCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/dcf_pkg.sv
// ----------------------------------------------------------------------------
// dcf_pkg
// Constants, microcode format and microcode ROM of the display command framer.
// ----------------------------------------------------------------------------
package dcf_pkg;

  localparam int TEXT_DEPTH_DEF = 32;
  localparam int STEP_W         = 5;

  // Operation codes
  localparam logic [3:0] OP_CLEAR    = 4'd0;
  localparam logic [3:0] OP_PIXEL    = 4'd1;
  localparam logic [3:0] OP_RECT     = 4'd2;
  localparam logic [3:0] OP_LINE     = 4'd3;
  localparam logic [3:0] OP_LIGHT    = 4'd4;
  localparam logic [3:0] OP_SOUND    = 4'd5;
  localparam logic [3:0] OP_CONTRAST = 4'd6;
  localparam logic [3:0] OP_INVERT   = 4'd7;
  localparam logic [3:0] OP_APPEND   = 4'd8;
  localparam logic [3:0] OP_SEND     = 4'd9;

  // Frame bytes
  localparam logic [7:0] BYTE_START = 8'hAA;
  localparam logic [7:0] BYTE_END   = 8'h55;
  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] TEXT_LEN_BASE = 8'h09;

  localparam logic [7:0] LEN_CLEAR = 8'h06;
  localparam logic [7:0] LEN_PIXEL = 8'h08;
  localparam logic [7:0] LEN_BOX   = 8'h10;
  localparam logic [7:0] LEN_VALUE = 8'h07;

  localparam logic [7:0] CODE_CLEAR    = 8'h02;
  localparam logic [7:0] CODE_PIXEL    = 8'h09;
  localparam logic [7:0] CODE_RECT     = 8'h07;
  localparam logic [7:0] CODE_LINE     = 8'h12;
  localparam logic [7:0] CODE_LIGHT    = 8'h14;
  localparam logic [7:0] CODE_SOUND    = 8'h06;
  localparam logic [7:0] CODE_CONTRAST = 8'h11;
  localparam logic [7:0] CODE_INVERT   = 8'h15;

  // Byte source select
  localparam logic [3:0] SRC_START = 4'd0;
  localparam logic [3:0] SRC_LEN   = 4'd1;
  localparam logic [3:0] SRC_ZERO  = 4'd2;
  localparam logic [3:0] SRC_CODE  = 4'd3;
  localparam logic [3:0] SRC_X     = 4'd4;
  localparam logic [3:0] SRC_Y     = 4'd5;
  localparam logic [3:0] SRC_W     = 4'd6;
  localparam logic [3:0] SRC_H     = 4'd7;
  localparam logic [3:0] SRC_V     = 4'd8;
  localparam logic [3:0] SRC_TEXT  = 4'd9;
  localparam logic [3:0] SRC_CSUM  = 4'd10;
  localparam logic [3:0] SRC_END   = 4'd11;

  // Sequencing
  localparam logic [2:0] JMP_NEXT      = 3'd0;
  localparam logic [2:0] JMP_DISPATCH  = 3'd1;
  localparam logic [2:0] JMP_TAIL      = 3'd2;
  localparam logic [2:0] JMP_SKIPEMPTY = 3'd3;
  localparam logic [2:0] JMP_TEXTLOOP  = 3'd4;
  localparam logic [2:0] JMP_DONE      = 3'd5;

  // Program addresses
  localparam logic [STEP_W-1:0] PC_START   = 5'd0;
  localparam logic [STEP_W-1:0] PC_PIXEL   = 5'd4;
  localparam logic [STEP_W-1:0] PC_BOX     = 5'd6;
  localparam logic [STEP_W-1:0] PC_VALUE   = 5'd10;
  localparam logic [STEP_W-1:0] PC_TEXT    = 5'd11;
  localparam logic [STEP_W-1:0] PC_TXTBYTE = 5'd14;
  localparam logic [STEP_W-1:0] PC_TERM    = 5'd15;
  localparam logic [STEP_W-1:0] PC_TAIL    = 5'd16;

  typedef struct packed {
    logic [3:0] src;
    logic [2:0] jmp;
    logic       sum_en;
  } uword_t;

  function automatic uword_t ucode(input logic [STEP_W-1:0] pc);
    uword_t w;
    unique case (pc)
      5'd0:    w = '{SRC_START, JMP_NEXT,      1'b0};
      5'd1:    w = '{SRC_LEN,   JMP_NEXT,      1'b1};
      5'd2:    w = '{SRC_ZERO,  JMP_NEXT,      1'b1};
      5'd3:    w = '{SRC_CODE,  JMP_DISPATCH,  1'b1};
      5'd4:    w = '{SRC_X,     JMP_NEXT,      1'b1};
      5'd5:    w = '{SRC_Y,     JMP_TAIL,      1'b1};
      5'd6:    w = '{SRC_X,     JMP_NEXT,      1'b1};
      5'd7:    w = '{SRC_Y,     JMP_NEXT,      1'b1};
      5'd8:    w = '{SRC_W,     JMP_NEXT,      1'b1};
      5'd9:    w = '{SRC_H,     JMP_TAIL,      1'b1};
      5'd10:   w = '{SRC_V,     JMP_TAIL,      1'b1};
      5'd11:   w = '{SRC_X,     JMP_NEXT,      1'b1};
      5'd12:   w = '{SRC_Y,     JMP_NEXT,      1'b1};
      5'd13:   w = '{SRC_W,     JMP_SKIPEMPTY, 1'b1};
      5'd14:   w = '{SRC_TEXT,  JMP_TEXTLOOP,  1'b1};
      5'd15:   w = '{SRC_ZERO,  JMP_NEXT,      1'b1};
      5'd16:   w = '{SRC_CSUM,  JMP_NEXT,      1'b0};
      5'd17:   w = '{SRC_END,   JMP_DONE,      1'b0};
      default: w = '{SRC_END,   JMP_DONE,      1'b0};
    endcase
    return w;
  endfunction

  function automatic logic [STEP_W-1:0] dispatch(input logic [3:0] op);
    logic [STEP_W-1:0] pc;
    unique case (op)
      OP_PIXEL:                                       pc = PC_PIXEL;
      OP_RECT, OP_LINE:                               pc = PC_BOX;
      OP_LIGHT, OP_SOUND, OP_CONTRAST, OP_INVERT:     pc = PC_VALUE;
      OP_SEND:                                        pc = PC_TEXT;
      default:                                        pc = PC_TAIL;
    endcase
    return pc;
  endfunction

  function automatic logic [7:0] fixed_len(input logic [3:0] op);
    logic [7:0] b;
    unique case (op)
      OP_PIXEL:         b = LEN_PIXEL;
      OP_RECT, OP_LINE: b = LEN_BOX;
      OP_LIGHT, OP_SOUND, OP_CONTRAST, OP_INVERT: b = LEN_VALUE;
      default:          b = LEN_CLEAR;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] fixed_code(input logic [3:0] op);
    logic [7:0] b;
    unique case (op)
      OP_PIXEL:    b = CODE_PIXEL;
      OP_RECT:     b = CODE_RECT;
      OP_LINE:     b = CODE_LINE;
      OP_LIGHT:    b = CODE_LIGHT;
      OP_SOUND:    b = CODE_SOUND;
      OP_CONTRAST: b = CODE_CONTRAST;
      OP_INVERT:   b = CODE_INVERT;
      default:     b = CODE_CLEAR;
    endcase
    return b;
  endfunction

endpackage

// File: hdl/dcf_ram.sv
// ----------------------------------------------------------------------------
// dcf_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = dcf_pkg::TEXT_DEPTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// File: hdl/display_command_framer_core.sv
// ----------------------------------------------------------------------------
// display_command_framer_core
// Turns display commands into serial byte frames, one byte per transaction.
// ----------------------------------------------------------------------------
// Each frame command produces one frame, one byte per output transaction:
// AA, length, 00, code, parameters, checksum, 55, with last_byte set on the 55.
// A small microcode ROM steps through the frame one control word per output
// byte. A command holds in_stall high while its frame is produced, including
// any time the output is stalled; frames run from 6 bytes (clear) to
// TEXT_DEPTH + 10 bytes (full text frame, 42 at the default depth). An
// append-text command raises no in_stall and produces nothing; bytes beyond
// TEXT_DEPTH are dropped. Codes 10 to 15 are consumed with no output and
// raise no in_stall.
module display_command_framer_core #(
  parameter int TEXT_DEPTH = dcf_pkg::TEXT_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] in_operation,
  input  logic [7:0] in_pos_x,
  input  logic [7:0] in_pos_y,
  input  logic [7:0] in_extent_w,
  input  logic [7:0] in_extent_h,
  input  logic [7:0] in_setting_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_frame_byte,
  output logic       out_last_byte
);

`include "display_command_framer_core_defines.svh"

  localparam int AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
  localparam int CW = $clog2(TEXT_DEPTH + 1);

  logic                        busy_r, busy_nxt;
  logic [dcf_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [3:0]                  op_r, op_nxt;
  logic [7:0]                  x_r, x_nxt, y_r, y_nxt, w_r, w_nxt, h_r, h_nxt, v_r, v_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [AW-1:0]               idx_r, idx_nxt;
  logic [7:0]                  csum_r, csum_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  out_byte_r, out_byte_nxt;
  logic                        out_last_r, out_last_nxt;

  dcf_pkg::uword_t             uw;
  logic [7:0]                  byte_sel;
  logic [7:0]                  text_rdata;
  logic                        adv, fire, accept, text_we, more_text;

  dcf_ram #(
    .WIDTH (8),
    .DEPTH (TEXT_DEPTH)
  ) u_text_ram (
    .clk   (clk),
    .we    (text_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_setting_value),
    .raddr (idx_nxt),
    .rdata (text_rdata)
  );

  assign in_stall       = busy_r;
  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_last_byte  = out_last_r;

  always_comb begin
    uw        = dcf_pkg::ucode(step_r);
    adv       = !out_valid_r || !out_stall;
    fire      = busy_r && adv;
    accept    = in_valid && !busy_r;
    more_text = (CW'(idx_r) + CW'(1)) < cnt_r;

    unique case (uw.src)
      dcf_pkg::SRC_START: byte_sel = dcf_pkg::BYTE_START;
      dcf_pkg::SRC_LEN:   byte_sel = (op_r == dcf_pkg::OP_SEND) ?
                                     8'(cnt_r) + dcf_pkg::TEXT_LEN_BASE :
                                     dcf_pkg::fixed_len(op_r);
      dcf_pkg::SRC_ZERO:  byte_sel = dcf_pkg::BYTE_ZERO;
      dcf_pkg::SRC_CODE:  byte_sel = (op_r == dcf_pkg::OP_SEND) ? v_r :
                                     dcf_pkg::fixed_code(op_r);
      dcf_pkg::SRC_X:     byte_sel = x_r;
      dcf_pkg::SRC_Y:     byte_sel = y_r;
      dcf_pkg::SRC_W:     byte_sel = w_r;
      dcf_pkg::SRC_H:     byte_sel = h_r;
      dcf_pkg::SRC_V:     byte_sel = v_r;
      dcf_pkg::SRC_TEXT:  byte_sel = text_rdata;
      dcf_pkg::SRC_CSUM:  byte_sel = csum_r;
      default:            byte_sel = dcf_pkg::BYTE_END;
    endcase

    busy_nxt      = busy_r;
    step_nxt      = step_r;
    op_nxt        = op_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    v_nxt         = v_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    csum_nxt      = csum_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    text_we       = 1'b0;

    if (accept) begin
      op_nxt = in_operation;
      x_nxt  = in_pos_x;
      y_nxt  = in_pos_y;
      w_nxt  = in_extent_w;
      h_nxt  = in_extent_h;
      v_nxt  = in_setting_value;
      if (in_operation == dcf_pkg::OP_APPEND) begin
        if (cnt_r < CW'(TEXT_DEPTH)) begin
          text_we = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
      end else if (in_operation <= dcf_pkg::OP_INVERT || in_operation == dcf_pkg::OP_SEND) begin
        busy_nxt = 1'b1;
        step_nxt = dcf_pkg::PC_START;
        csum_nxt = '0;
        idx_nxt  = '0;
      end
    end

    if (adv) begin
      out_valid_nxt = busy_r;
    end

    if (fire) begin
      out_byte_nxt = byte_sel;
      out_last_nxt = (uw.jmp == dcf_pkg::JMP_DONE);
      if (uw.sum_en) begin
        csum_nxt = csum_r + byte_sel;
      end
      unique case (uw.jmp)
        dcf_pkg::JMP_DISPATCH:  step_nxt = dcf_pkg::dispatch(op_r);
        dcf_pkg::JMP_TAIL:      step_nxt = dcf_pkg::PC_TAIL;
        dcf_pkg::JMP_SKIPEMPTY: step_nxt = (cnt_r == '0) ? dcf_pkg::PC_TERM :
                                                           dcf_pkg::PC_TXTBYTE;
        dcf_pkg::JMP_TEXTLOOP: begin
          if (more_text) begin
            step_nxt = dcf_pkg::PC_TXTBYTE;
            idx_nxt  = idx_r + AW'(1);
          end else begin
            step_nxt = dcf_pkg::PC_TERM;
          end
        end
        dcf_pkg::JMP_DONE: begin
          step_nxt = dcf_pkg::PC_START;
          busy_nxt = 1'b0;
          if (op_r == dcf_pkg::OP_SEND) begin
            cnt_nxt = '0;
          end
        end
        default:                step_nxt = step_r + dcf_pkg::STEP_W'(1);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= dcf_pkg::PC_START;
      cnt_r       <= '0;
      idx_r       <= '0;
      csum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      csum_r      <= csum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    w_r        <= w_nxt;
    h_r        <= h_nxt;
    v_r        <= v_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  `DCF_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CW'(TEXT_DEPTH), "text count beyond depth")
  `DCF_ASSERT_NOW(a_idle_step, !busy_r, step_r == dcf_pkg::PC_START, "sequencer not parked")
  `DCF_ASSERT_NOW(a_frame_end, $fell(busy_r), out_valid_r && out_last_r &&
                  out_byte_r == dcf_pkg::BYTE_END, "frame ended without closing byte")
  `DCF_ASSERT_NEXT(a_send_clears, fire && uw.jmp == dcf_pkg::JMP_DONE &&
                   op_r == dcf_pkg::OP_SEND, cnt_r == '0, "text store not emptied")

endmodule

// File: verif/dcf_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dcf_frame_checker
// Watches both channels of the display command framer. Each accepted command
// transaction is expanded into its expected frame bytes. Each accepted output
// transaction is checked against the oldest outstanding byte.
// ----------------------------------------------------------------------------
module dcf_frame_checker #(
  parameter int TEXT_DEPTH = dcf_pkg::TEXT_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [3:0] in_operation,
  input  logic [7:0] in_pos_x,
  input  logic [7:0] in_pos_y,
  input  logic [7:0] in_extent_w,
  input  logic [7:0] in_extent_h,
  input  logic [7:0] in_setting_value,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_frame_byte,
  input  logic       out_last_byte,
  output int         errors,
  output int         pending,
  output int         frames_seen,
  output int         bytes_seen
);
  import dcf_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  frame_byte_t bytes_due[$];
  logic [7:0]  text_buf[TEXT_DEPTH];
  logic [5:0]  text_len = '0;
  int          n_err = 0;
  int          n_frames = 0;
  int          n_bytes = 0;

  task automatic frame_command(input logic [3:0] op, input logic [7:0] x, y, w, h, v);
    logic [7:0]  frame[$];
    logic [7:0]  csum;
    frame_byte_t entry;
    frame.delete();
    csum = BYTE_ZERO;
    case (op)
      OP_CLEAR:    frame = '{BYTE_START, LEN_CLEAR, BYTE_ZERO, CODE_CLEAR};
      OP_PIXEL:    frame = '{BYTE_START, LEN_PIXEL, BYTE_ZERO, CODE_PIXEL, x, y};
      OP_RECT:     frame = '{BYTE_START, LEN_BOX, BYTE_ZERO, CODE_RECT, x, y, w, h};
      OP_LINE:     frame = '{BYTE_START, LEN_BOX, BYTE_ZERO, CODE_LINE, x, y, w, h};
      OP_LIGHT:    frame = '{BYTE_START, LEN_VALUE, BYTE_ZERO, CODE_LIGHT, v};
      OP_SOUND:    frame = '{BYTE_START, LEN_VALUE, BYTE_ZERO, CODE_SOUND, v};
      OP_CONTRAST: frame = '{BYTE_START, LEN_VALUE, BYTE_ZERO, CODE_CONTRAST, v};
      OP_INVERT:   frame = '{BYTE_START, LEN_VALUE, BYTE_ZERO, CODE_INVERT, v};
      OP_APPEND: begin
        // full store drops the byte
        if (text_len < TEXT_DEPTH) begin
          text_buf[text_len] = v;
          text_len = text_len + 6'd1;
        end
      end
      OP_SEND: begin
        frame = '{BYTE_START, 8'(text_len) + TEXT_LEN_BASE, BYTE_ZERO, v, x, y, w};
        for (int i = 0; i < text_len; i++) frame.push_back(text_buf[i]);
        frame.push_back(BYTE_ZERO);
        text_len = '0;
      end
      default: ;
    endcase
    if (frame.size() > 0) begin
      for (int i = 1; i < frame.size(); i++) csum = csum + frame[i];
      frame.push_back(csum);
      frame.push_back(BYTE_END);
      foreach (frame[k]) begin
        entry.data = frame[k];
        entry.last = (k == frame.size() - 1);
        bytes_due.push_back(entry);
      end
    end
  endtask

  always @(posedge clk) begin
    frame_byte_t exp_byte;
    if (!rst_n) begin
      text_len = '0;
      bytes_due.delete();
    end else begin
      // push first so a same-cycle output still finds its expectation
      if (in_valid && !in_stall) begin
        frame_command(in_operation, in_pos_x, in_pos_y, in_extent_w, in_extent_h,
                      in_setting_value);
      end
      if (out_valid && !out_stall) begin
        n_bytes++;
        if (bytes_due.size() == 0) begin
          n_err++;
          if (n_err <= MAX_REPORTS) begin
            $display("unexpected output transaction: byte %02h last %0b",
                     out_frame_byte, out_last_byte);
          end
        end else begin
          exp_byte = bytes_due.pop_front();
          if (exp_byte.last) n_frames++;
          if (out_frame_byte !== exp_byte.data || out_last_byte !== exp_byte.last) begin
            n_err++;
            if (n_err <= MAX_REPORTS) begin
              $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                       exp_byte.data, exp_byte.last, out_frame_byte, out_last_byte);
            end
          end
        end
      end
    end
    errors      <= n_err;
    pending     <= bytes_due.size();
    frames_seen <= n_frames;
    bytes_seen  <= n_bytes;
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the display command framer: a directed pass over every command
// and its field extremes, a text store overflow, a long output hold-off, then
// a random mix of commands and text sequences with random idling on both
// channels. Checking is done by dcf_frame_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import dcf_pkg::*;

  localparam int         DEPTH          = TEXT_DEPTH_DEF;
  localparam int         TOTAL_COMMANDS = 270;
  localparam int         HOLD_CYCLES    = 200;
  localparam int         DRAIN_CYCLES   = 2 * (DEPTH + 10);
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam logic [3:0] OP_UNUSED_LO   = 4'd10;
  localparam logic [3:0] OP_UNUSED_HI   = 4'd15;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [3:0] in_operation = OP_CLEAR;
  logic [7:0] in_pos_x = '0;
  logic [7:0] in_pos_y = '0;
  logic [7:0] in_extent_w = '0;
  logic [7:0] in_extent_h = '0;
  logic [7:0] in_setting_value = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_frame_byte;
  logic       out_last_byte;

  logic calm = 1'b0;
  logic hold_tgl = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   quiet = 0;
  int   commands_sent = 0;
  int   errors, pending, frames_seen, bytes_seen;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  display_command_framer_core #(.TEXT_DEPTH(DEPTH)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_extent_w      (in_extent_w),
    .in_extent_h      (in_extent_h),
    .in_setting_value (in_setting_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_byte   (out_frame_byte),
    .out_last_byte    (out_last_byte)
  );

  dcf_frame_checker #(.TEXT_DEPTH(DEPTH)) frame_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_extent_w      (in_extent_w),
    .in_extent_h      (in_extent_h),
    .in_setting_value (in_setting_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_byte   (out_frame_byte),
    .out_last_byte    (out_last_byte),
    .errors           (errors),
    .pending          (pending),
    .frames_seen      (frames_seen),
    .bytes_seen       (bytes_seen)
  );

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_tgl != hold_seen) begin
      hold_seen <= hold_tgl;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 32);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d bytes outstanding",
               quiet, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic issue_command(input logic [3:0] op, input logic [7:0] x, y, w, h, v);
    while (!calm && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_pos_x         <= x;
    in_pos_y         <= y;
    in_extent_w      <= w;
    in_extent_h      <= h;
    in_setting_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op <= OP_SEND) commands_sent++;
  endtask

  task automatic issue_random(input logic [3:0] op);
    issue_command(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
  endtask

  task automatic issue_text(input int n);
    repeat (n) issue_random(OP_APPEND);
    issue_random(OP_SEND);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int pick;
    int n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    issue_command(OP_CLEAR,    8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    issue_command(OP_CLEAR,    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    issue_command(OP_PIXEL,    8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    issue_command(OP_PIXEL,    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    issue_command(OP_RECT,     8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    issue_command(OP_RECT,     8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    issue_command(OP_LINE,     8'h00, 8'hFF, 8'hFF, 8'h00, 8'h5A);
    issue_command(OP_LIGHT,    8'h00, 8'h00, 8'h00, 8'h00, 8'hFF);
    issue_command(OP_SOUND,    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    issue_command(OP_CONTRAST, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF);
    issue_command(OP_INVERT,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    issue_command(OP_INVERT,   8'h00, 8'h00, 8'h00, 8'h00, 8'h01);
    issue_command(OP_SEND,     8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
    issue_command(OP_APPEND,   8'h00, 8'h00, 8'h00, 8'h00, 8'hFF);
    issue_command(OP_APPEND,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    issue_command(OP_APPEND,   8'h00, 8'h00, 8'h00, 8'h00, 8'hA5);
    issue_command(OP_SEND,     8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00);
    issue_command(OP_UNUSED_LO, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    issue_command(OP_UNUSED_HI, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

    // overflow the text store, then stall the output while commands keep coming
    issue_text(DEPTH + 4);
    hold_tgl <= ~hold_tgl;
    repeat (8) issue_random(4'($urandom_range(OP_INVERT)));
    in_valid <= 1'b0;
    wait_drained();

    while (commands_sent < TOTAL_COMMANDS) begin
      calm <= (commands_sent >= 150 && commands_sent < 220);
      pick = $urandom_range(99);
      if (pick < 55) begin
        issue_random(4'($urandom_range(OP_INVERT)));
      end else if (pick < 80) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(DEPTH + 4) : $urandom_range(8);
        issue_text(n);
      end else if (pick < 88) begin
        issue_random(OP_APPEND);
      end else if (pick < 94) begin
        issue_random(OP_SEND);
      end else begin
        issue_random(4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO)));
      end
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d commands incl. text overflow, unused codes and a long hold-off;",
             commands_sent);
    $display("checked %0d frames, %0d bytes, %0d mismatches", frames_seen, bytes_seen,
             errors);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/dcf_pkg.sv
hdl/dcf_ram.sv
hdl/display_command_framer_core.sv
verif/dcf_frame_checker.sv
verif/tb_top.sv
